// File: rtl/core/dojq_pkg.sv
// Shared types and codes for the deadline ordered job queue.
// No dependencies; used by every module of the block.
`default_nettype none
package dojq_pkg;

  localparam int NUM_QUEUES_DEF      = 4;
  localparam int SLOTS_PER_QUEUE_DEF = 16;
  localparam int RESERVED_QUEUE_DEF  = 0;

  typedef enum logic [2:0] {
    ST_PUSHED = 3'd0,
    ST_BUSY   = 3'd1,
    ST_BAD_ID = 3'd2,
    ST_FULL   = 3'd3,
    ST_POPPED = 3'd4,
    ST_NONE   = 3'd5
  } status_t;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  // One classified item passed from the front end to the back end.
  typedef struct packed {
    logic        mode;
    logic [1:0]  q;
    logic [15:0] job_id;
    logic [31:0] tag;
    logic [47:0] deadline;
    logic [47:0] now;
    logic        qbad;
    logic        is_res;
    logic        badid;
  } cmd_t;

endpackage
`default_nettype wire

// File: rtl/core/deadline_ordered_job_queue.sv
// Deadline ordered job queue: several slot pools, each a list sorted by deadline.
// Top level; instantiates dojq_front, dojq_fifo and dojq_back, uses dojq_pkg.
//
// Input channel (in_valid/in_stall): mode, queue_sel, job_id, delay, data_tag,
// now. An item is taken when in_valid is high and in_stall low. A push stores
// the job with deadline now+delay (mod 2^48) behind all entries with equal or
// earlier deadline; a pop removes the queue head when now >= its deadline.
// Output channel (out_valid/out_stall): one result item per input item,
// status, out_job_id, out_data_tag, in input order.
// Sequence: a rejected push or a pop on an empty queue goes from idle straight to
// the result state, a pop on a filled queue passes the compare state first; an
// accepted push walks a non-empty list, comparing entries (at most SLOTS_PER_QUEUE-1),
// then links the new entry, also rewriting the entry before it when linking behind
// one. The walk reads one slot entry per cycle from the slot memory.
// A two-item queue sits between the input side and the execution engine, so
// while a result waits under out_stall up to three more items are taken (one
// held in the engine, two in the queue); then in_stall rises.
// Reset empties all queues and clears out_valid.
`default_nettype none
module deadline_ordered_job_queue #(
  parameter int NUM_QUEUES      = dojq_pkg::NUM_QUEUES_DEF,
  parameter int SLOTS_PER_QUEUE = dojq_pkg::SLOTS_PER_QUEUE_DEF,
  parameter int RESERVED_QUEUE  = dojq_pkg::RESERVED_QUEUE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        mode,
  input  wire logic [1:0]  queue_sel,
  input  wire logic [15:0] job_id,
  input  wire logic [31:0] delay,
  input  wire logic [31:0] data_tag,
  input  wire logic [47:0] now,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic [15:0]      out_job_id,
  output logic [31:0]      out_data_tag
);
  import dojq_pkg::*;

  cmd_t cmd_front;
  cmd_t cmd_back;
  logic fifo_full;
  logic fifo_ne;
  logic cmd_take;

  assign in_stall = fifo_full;

  dojq_front #(
    .NUM_QUEUES(NUM_QUEUES), .SLOTS_PER_QUEUE(SLOTS_PER_QUEUE),
    .RESERVED_QUEUE(RESERVED_QUEUE)
  ) u_front (
    .mode(mode), .queue_sel(queue_sel), .job_id(job_id), .delay(delay),
    .data_tag(data_tag), .now(now), .cmd(cmd_front)
  );

  dojq_fifo u_fifo (
    .clk(clk), .rst(rst), .wr_en(in_valid && !fifo_full), .wr_data(cmd_front),
    .full(fifo_full), .not_empty(fifo_ne), .rd_en(cmd_take), .rd_data(cmd_back)
  );

  dojq_back #(
    .NUM_QUEUES(NUM_QUEUES), .SLOTS_PER_QUEUE(SLOTS_PER_QUEUE)
  ) u_back (
    .clk(clk), .rst(rst), .cmd_valid(fifo_ne), .cmd_in(cmd_back),
    .cmd_take(cmd_take), .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .out_job_id(out_job_id), .out_data_tag(out_data_tag)
  );

endmodule
`default_nettype wire

// File: rtl/core/dojq_front.sv
// Front end: accepts items, computes the deadline and classifies the queue/id.
// Depends on dojq_pkg.
`default_nettype none
module dojq_front #(
  parameter int NUM_QUEUES      = dojq_pkg::NUM_QUEUES_DEF,
  parameter int SLOTS_PER_QUEUE = dojq_pkg::SLOTS_PER_QUEUE_DEF,
  parameter int RESERVED_QUEUE  = dojq_pkg::RESERVED_QUEUE_DEF
) (
  input  wire logic          mode,
  input  wire logic [1:0]    queue_sel,
  input  wire logic [15:0]   job_id,
  input  wire logic [31:0]   delay,
  input  wire logic [31:0]   data_tag,
  input  wire logic [47:0]   now,
  output dojq_pkg::cmd_t     cmd
);
  import dojq_pkg::*;

  logic [48:0] sum;

  always_comb begin
    sum          = {1'b0, now} + {17'd0, delay};
    cmd.mode     = mode;
    cmd.q        = queue_sel;
    cmd.job_id   = job_id;
    cmd.tag      = data_tag;
    cmd.deadline = sum[47:0];
    cmd.now      = now;
    cmd.qbad     = (32'(queue_sel) >= NUM_QUEUES);
    cmd.is_res   = (32'(queue_sel) == RESERVED_QUEUE);
    cmd.badid    = (32'(job_id) >= SLOTS_PER_QUEUE);
  end

endmodule
`default_nettype wire

// File: rtl/core/dojq_fifo.sv
// Two-entry queue of classified items between front and back end.
// Depends on dojq_pkg.
`default_nettype none
module dojq_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  dojq_pkg::cmd_t     wr_data,
  output logic               full,
  output logic               not_empty,
  input  wire logic          rd_en,
  output dojq_pkg::cmd_t     rd_data
);
  import dojq_pkg::*;

  cmd_t       mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign rd_data   = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_en) wp <= ~wp;
      if (rd_en) rp <= ~rp;
      count <= count + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/dojq_back.sv
// Back end: slot pool, sorted list walk, pop and the output register.
// Depends on dojq_pkg; fed from dojq_fifo.
`default_nettype none
module dojq_back #(
  parameter int NUM_QUEUES      = dojq_pkg::NUM_QUEUES_DEF,
  parameter int SLOTS_PER_QUEUE = dojq_pkg::SLOTS_PER_QUEUE_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  input  dojq_pkg::cmd_t     cmd_in,
  output logic               cmd_take,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [2:0]         status,
  output logic [15:0]        out_job_id,
  output logic [31:0]        out_data_tag
);
  import dojq_pkg::*;

  localparam int SPQ    = SLOTS_PER_QUEUE;
  localparam int TOTAL  = NUM_QUEUES * SLOTS_PER_QUEUE;
  localparam int SW     = $clog2(SPQ);
  localparam int SW1    = $clog2(SPQ + 1);
  localparam int QW     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int ADDR_W = $clog2(TOTAL);
  localparam logic [SW1-1:0] NO_SLOT = SW1'(SPQ);

  typedef struct packed {
    logic [15:0]    job_id;
    logic [47:0]    deadline;
    logic [31:0]    tag;
    logic [SW1-1:0] nxt;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE, S_WALK, S_LINK, S_LINK2, S_POP_CMP, S_RESP
  } state_t;

  state_t              state;
  cmd_t                cur_cmd;
  logic [SW1-1:0]      slot;
  logic [SW1-1:0]      cur;
  logic [SW1-1:0]      prev;
  entry_t              prev_entry;
  status_t             res_status;
  logic [15:0]         res_id;
  logic [31:0]         res_tag;
  logic [TOTAL-1:0]    used;
  logic [SW1-1:0]      head [NUM_QUEUES];

  entry_t              mem [TOTAL];
  entry_t              rd_data;
  logic [ADDR_W-1:0]   rd_addr;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  entry_t              wr_data;

  logic [QW-1:0]       in_qi;
  logic [QW-1:0]       cur_qi;
  logic [ADDR_W-1:0]   in_base;
  logic [ADDR_W-1:0]   cur_base;
  logic [SW1-1:0]      in_head;
  logic [SPQ-1:0]      in_used;
  logic [SW1-1:0]      free_slot;
  logic [ADDR_W-1:0]   res_addr;

  function automatic logic [SW1-1:0] first_free(input logic [SPQ-1:0] v);
    logic [SW1-1:0] r;
    r = SW1'(SPQ);
    for (int i = SPQ - 1; i >= 0; i--) begin
      if (!v[i]) r = SW1'(i);
    end
    return r;
  endfunction

  always_comb begin
    in_qi     = QW'(cmd_in.q);
    cur_qi    = QW'(cur_cmd.q);
    in_base   = ADDR_W'(32'(in_qi) * SPQ);
    cur_base  = ADDR_W'(32'(cur_qi) * SPQ);
    in_head   = cmd_in.qbad ? NO_SLOT : head[in_qi];
    in_used   = used[in_base +: SPQ];
    free_slot = first_free(in_used);
    res_addr  = in_base + ADDR_W'(cmd_in.job_id[SW-1:0]);
    if (state == S_WALK) rd_addr = cur_base + ADDR_W'(rd_data.nxt[SW-1:0]);
    else                 rd_addr = in_base + ADDR_W'(in_head[SW-1:0]);
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_base + ADDR_W'(slot[SW-1:0]);
    wr_data = '{job_id: cur_cmd.job_id, deadline: cur_cmd.deadline,
                tag: cur_cmd.tag, nxt: cur};
    if (state == S_LINK) begin
      wr_en = 1'b1;
    end else if (state == S_LINK2) begin
      wr_en       = 1'b1;
      wr_addr     = cur_base + ADDR_W'(prev[SW-1:0]);
      wr_data     = prev_entry;
      wr_data.nxt = slot;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  assign cmd_take = (state == S_IDLE) && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) head[i] <= NO_SLOT;
    end else begin
      // S_RESP reloads the output register itself
      if (state != S_RESP && out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur_cmd    <= cmd_in;
            res_id     <= '0;
            res_tag    <= '0;
            prev       <= NO_SLOT;
            cur        <= in_head;
            if (cmd_in.mode == MODE_PUSH) begin
              if (cmd_in.qbad) begin
                res_status <= ST_FULL;
                state      <= S_RESP;
              end else if (cmd_in.is_res && cmd_in.badid) begin
                res_status <= ST_BAD_ID;
                state      <= S_RESP;
              end else if (cmd_in.is_res && used[res_addr]) begin
                res_status <= ST_BUSY;
                state      <= S_RESP;
              end else if (!cmd_in.is_res && free_slot == NO_SLOT) begin
                res_status <= ST_FULL;
                state      <= S_RESP;
              end else begin
                res_status <= ST_PUSHED;
                if (cmd_in.is_res) begin
                  slot <= SW1'(cmd_in.job_id[SW-1:0]);
                  used[res_addr] <= 1'b1;
                end else begin
                  slot <= free_slot;
                  used[in_base + ADDR_W'(free_slot[SW-1:0])] <= 1'b1;
                end
                state <= (in_head == NO_SLOT) ? S_LINK : S_WALK;
              end
            end else if (in_head == NO_SLOT) begin
              res_status <= ST_NONE;
              state      <= S_RESP;
            end else begin
              state <= S_POP_CMP;
            end
          end
        end
        S_WALK: begin
          // equal deadlines go after existing entries
          if (rd_data.deadline <= cur_cmd.deadline) begin
            prev       <= cur;
            prev_entry <= rd_data;
            cur        <= rd_data.nxt;
            if (rd_data.nxt == NO_SLOT) state <= S_LINK;
          end else begin
            state <= S_LINK;
          end
        end
        S_LINK: begin
          if (prev == NO_SLOT) begin
            head[cur_qi] <= slot;
            state        <= S_RESP;
          end else begin
            state <= S_LINK2;
          end
        end
        S_LINK2: state <= S_RESP;
        S_POP_CMP: begin
          if (cur_cmd.now >= rd_data.deadline) begin
            head[cur_qi] <= rd_data.nxt;
            used[cur_base + ADDR_W'(cur[SW-1:0])] <= 1'b0;
            res_status   <= ST_POPPED;
            res_id       <= rd_data.job_id;
            res_tag      <= rd_data.tag;
          end else begin
            res_status <= ST_NONE;
          end
          state <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            out_job_id   <= res_id;
            out_data_tag <= res_tag;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_resp_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP && !out_valid) |=> out_valid)
    else $error("result not loaded into free output register");
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_POPPED) |-> (out_job_id == '0 && out_data_tag == '0))
    else $error("non-pop result carries job fields");
  a_walk_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (cur != NO_SLOT))
    else $error("list walk on empty marker");

endmodule
`default_nettype wire
